[rtl/flcu_pkg.sv]
// ----------------------------------------------------------------------------
// Free-look camera update package
// State codes, command codes, register indexes and fixed-point constants
// shared by the camera update logic.
// ----------------------------------------------------------------------------
package flcu_pkg;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_MOVE_V,
		ST_MOVE_STEP,
		ST_ZOOM,
		ST_LOOK_Y,
		ST_LOOK_P,
		ST_WRAP,
		ST_TRIG_INIT,
		ST_TRIG_ITER,
		ST_TRIG_END,
		ST_FRONT0,
		ST_FRONT1,
		ST_NORM_SQ,
		ST_NORM_CHK,
		ST_NORM_ROOT,
		ST_DIV_LD,
		ST_DIV,
		ST_DIV_ST,
		ST_NORM_NEXT,
		ST_CROSS,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		CMD_MOVE = 2'd0,
		CMD_LOOK = 2'd1,
		CMD_ZOOM = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	localparam logic [2:0] DIR_FWD   = 3'd0;
	localparam logic [2:0] DIR_BACK  = 3'd1;
	localparam logic [2:0] DIR_LEFT  = 3'd2;
	localparam logic [2:0] DIR_RIGHT = 3'd3;
	localparam logic [2:0] DIR_UP    = 3'd4;
	localparam logic [2:0] DIR_DOWN  = 3'd5;
	localparam logic [2:0] DIR_ROLL  = 3'd6;

	localparam logic [2:0] CFG_SPEED = 3'd0;
	localparam logic [2:0] CFG_SENS  = 3'd1;
	localparam logic [2:0] CFG_ZMIN  = 3'd2;
	localparam logic [2:0] CFG_ZMAX  = 3'd3;
	localparam logic [2:0] CFG_WUP_X = 3'd4;
	localparam logic [2:0] CFG_WUP_Y = 3'd5;
	localparam logic [2:0] CFG_WUP_Z = 3'd6;

	localparam logic [1:0] PH_FRONT = 2'd0;
	localparam logic [1:0] PH_RIGHT = 2'd1;
	localparam logic [1:0] PH_UP    = 2'd2;

	localparam logic signed [31:0] ANG_HALF    = 32'sd11796480;
	localparam logic signed [31:0] ANG_FULL    = 32'sd23592960;
	localparam logic signed [31:0] ANG_QUARTER = 32'sd5898240;
	localparam logic signed [31:0] PITCH_LIM   = 32'sd5832704;
	localparam logic signed [31:0] CORDIC_X0   = 32'sd10187580;
	localparam logic signed [15:0] ONE_Q14     = 16'sd16384;

	function automatic logic [22:0] atan_lut(input logic [3:0] i);
		logic [22:0] r;
		case (i)
			4'd0:    r = 23'd2949120;
			4'd1:    r = 23'd1740967;
			4'd2:    r = 23'd919879;
			4'd3:    r = 23'd466945;
			4'd4:    r = 23'd234379;
			4'd5:    r = 23'd117304;
			4'd6:    r = 23'd58666;
			4'd7:    r = 23'd29335;
			4'd8:    r = 23'd14668;
			4'd9:    r = 23'd7334;
			4'd10:   r = 23'd3667;
			4'd11:   r = 23'd1833;
			4'd12:   r = 23'd917;
			4'd13:   r = 23'd458;
			4'd14:   r = 23'd229;
			default: r = 23'd115;
		endcase
		return r;
	endfunction

endpackage

[rtl/free_look_camera_update.sv]
// ----------------------------------------------------------------------------
// Free-look camera update
// Euler-angle fly camera: move, look and zoom commands on a shared multiplier,
// CORDIC, square root and divider under one sequencer.
// ----------------------------------------------------------------------------
// Commands arrive as beats on the s_axis channel, one command per beat, and
// each command gives exactly one result beat on the m_axis channel carrying
// position, front and up vectors, yaw, pitch and zoom after the command.
// s_axis_tready is high only while the sequencer is idle; one command is in
// work at a time.
// A move in the roll direction and the unused command go straight to the result
// register. A look command wraps the angles in a loop, runs the 16-step CORDIC
// twice and then, for each vector, the 32-step square root and, per vector
// component, the 15-step divider; all products use one 33 x 33 multiplier.
// The result register holds a finished beat while the receiver stalls; the
// next command still runs and waits in its last state until the register
// is free.
// Reset restores the default camera pose and register values; registers on
// the cfg port are to be written only while the block is idle (not enforced).
// ----------------------------------------------------------------------------
module free_look_camera_update (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// direction, time_step, x_offset, y_offset, clamp_pitch, zero fill
	input  logic [55:0]  s_axis_tdata,
	// cmd
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// position_x, position_y, position_z, front_x, front_y, front_z,
	// camera_up_x, camera_up_y, camera_up_z, yaw_angle, pitch_angle,
	// zoom_level, zero fill
	output logic [263:0] m_axis_tdata,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [15:0]  cfg_data
);

	flcu_pkg::state_t state_q, state_next;

	logic [15:0] speed_q, sens_q, zmin_q, zmax_q;
	logic signed [15:0] wu_q [3];

	logic signed [31:0] pos_q [3];
	logic signed [15:0] front_q [3];
	logic signed [15:0] right_q [3];
	logic signed [15:0] up_q [3];
	logic signed [24:0] yaw_q, pitch_q;
	logic [15:0] zoom_q;

	logic [2:0] dir_q;
	logic [15:0] dt_q;
	logic signed [15:0] xo_q, yo_q;
	logic clamp_q;

	logic [4:0] cnt_q;
	logic [1:0] k_q;
	logic [1:0] phase_q;
	logic sel_q;
	logic [31:0] v_q;
	logic signed [31:0] tv_q [3];
	logic [63:0] acc_q;
	logic [63:0] rt_q;
	logic [45:0] rem_q;
	logic [14:0] quo_q;
	logic signed [29:0] ya_q, pa_q;
	logic signed [31:0] cx_q, cy_q, cz_q;
	logic neg_q;
	logic signed [15:0] cos_y_q, sin_y_q, cos_p_q, sin_p_q;
	logic signed [31:0] prod_q;
	logic m_valid_q;
	logic [263:0] m_data_q;

	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_p;
	logic signed [15:0] ca [3];
	logic signed [15:0] cb [3];
	logic [1:0] ci1, ci2;
	logic signed [15:0] mv;
	logic y_hi, y_lo, p_hi, p_lo;
	logic out_free;

	logic signed [29:0] half30, full30;
	assign half30 = flcu_pkg::ANG_HALF[29:0];
	assign full30 = flcu_pkg::ANG_FULL[29:0];

	function automatic logic signed [15:0] sat_q14(input logic signed [31:0] v);
		logic signed [15:0] r;
		if (v > 32'sd16384) begin
			r = flcu_pkg::ONE_Q14;
		end else if (v < -32'sd16384) begin
			r = -flcu_pkg::ONE_Q14;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	assign mul_p = mul_a * mul_b;
	assign out_free = !m_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == flcu_pkg::ST_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = m_data_q;

	assign y_hi = (ya_q >= half30);
	assign y_lo = (ya_q < -half30);
	assign p_hi = (pa_q >= half30);
	assign p_lo = (pa_q < -half30);

	always_comb begin
		if (dir_q < flcu_pkg::DIR_LEFT) begin
			mv = front_q[k_q];
		end else if (dir_q < flcu_pkg::DIR_UP) begin
			mv = right_q[k_q];
		end else begin
			mv = up_q[k_q];
		end
		for (int j = 0; j < 3; j++) begin
			ca[j] = (phase_q == flcu_pkg::PH_RIGHT) ? front_q[j] : right_q[j];
			cb[j] = (phase_q == flcu_pkg::PH_RIGHT) ? wu_q[j] : front_q[j];
		end
		unique case (cnt_q[2:1])
			2'd0: begin
				ci1 = 2'd1;
				ci2 = 2'd2;
			end
			2'd1: begin
				ci1 = 2'd2;
				ci2 = 2'd0;
			end
			default: begin
				ci1 = 2'd0;
				ci2 = 2'd1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= flcu_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			flcu_pkg::ST_IDLE: begin
				if (s_axis_tvalid) begin
					unique case (flcu_pkg::cmd_t'(s_axis_tuser))
						flcu_pkg::CMD_MOVE: begin
							state_next = (s_axis_tdata[2:0] < flcu_pkg::DIR_ROLL) ?
								flcu_pkg::ST_MOVE_V : flcu_pkg::ST_DONE;
						end
						flcu_pkg::CMD_LOOK: state_next = flcu_pkg::ST_LOOK_Y;
						flcu_pkg::CMD_ZOOM: state_next = flcu_pkg::ST_ZOOM;
						default: state_next = flcu_pkg::ST_DONE;
					endcase
				end
			end
			flcu_pkg::ST_MOVE_V: begin
				mul_a = $signed({17'd0, speed_q});
				mul_b = $signed({17'd0, dt_q});
				state_next = flcu_pkg::ST_MOVE_STEP;
			end
			flcu_pkg::ST_MOVE_STEP: begin
				mul_a = 33'(mv);
				mul_b = $signed({1'b0, v_q});
				if (k_q == 2'd2) begin
					state_next = flcu_pkg::ST_DONE;
				end
			end
			flcu_pkg::ST_ZOOM: state_next = flcu_pkg::ST_DONE;
			flcu_pkg::ST_LOOK_Y: begin
				mul_a = 33'(xo_q);
				mul_b = $signed({17'd0, sens_q});
				state_next = flcu_pkg::ST_LOOK_P;
			end
			flcu_pkg::ST_LOOK_P: begin
				mul_a = 33'(yo_q);
				mul_b = $signed({17'd0, sens_q});
				state_next = flcu_pkg::ST_WRAP;
			end
			flcu_pkg::ST_WRAP: begin
				if (!y_hi && !y_lo && !p_hi && !p_lo) begin
					state_next = flcu_pkg::ST_TRIG_INIT;
				end
			end
			flcu_pkg::ST_TRIG_INIT: state_next = flcu_pkg::ST_TRIG_ITER;
			flcu_pkg::ST_TRIG_ITER: begin
				if (cnt_q == 5'd15) begin
					state_next = flcu_pkg::ST_TRIG_END;
				end
			end
			flcu_pkg::ST_TRIG_END: begin
				state_next = sel_q ? flcu_pkg::ST_FRONT0 : flcu_pkg::ST_TRIG_INIT;
			end
			flcu_pkg::ST_FRONT0: begin
				mul_a = 33'(cos_y_q);
				mul_b = 33'(cos_p_q);
				state_next = flcu_pkg::ST_FRONT1;
			end
			flcu_pkg::ST_FRONT1: begin
				mul_a = 33'(sin_y_q);
				mul_b = 33'(cos_p_q);
				state_next = flcu_pkg::ST_NORM_SQ;
			end
			flcu_pkg::ST_NORM_SQ: begin
				mul_a = 33'(tv_q[k_q]);
				mul_b = 33'(tv_q[k_q]);
				if (k_q == 2'd2) begin
					state_next = flcu_pkg::ST_NORM_CHK;
				end
			end
			flcu_pkg::ST_NORM_CHK: begin
				state_next = (acc_q == 64'd0) ? flcu_pkg::ST_NORM_NEXT :
					flcu_pkg::ST_NORM_ROOT;
			end
			flcu_pkg::ST_NORM_ROOT: begin
				if (cnt_q == 5'd31) begin
					state_next = flcu_pkg::ST_DIV_LD;
				end
			end
			flcu_pkg::ST_DIV_LD: state_next = flcu_pkg::ST_DIV;
			flcu_pkg::ST_DIV: begin
				if (cnt_q == 5'd0) begin
					state_next = flcu_pkg::ST_DIV_ST;
				end
			end
			flcu_pkg::ST_DIV_ST: begin
				state_next = (k_q == 2'd2) ? flcu_pkg::ST_NORM_NEXT : flcu_pkg::ST_DIV_LD;
			end
			flcu_pkg::ST_NORM_NEXT: begin
				state_next = (phase_q == flcu_pkg::PH_UP) ? flcu_pkg::ST_DONE :
					flcu_pkg::ST_CROSS;
			end
			flcu_pkg::ST_CROSS: begin
				if (cnt_q[0]) begin
					mul_a = 33'(ca[ci2]);
					mul_b = 33'(cb[ci1]);
				end else begin
					mul_a = 33'(ca[ci1]);
					mul_b = 33'(cb[ci2]);
				end
				if (cnt_q == 5'd5) begin
					state_next = flcu_pkg::ST_NORM_SQ;
				end
			end
			flcu_pkg::ST_DONE: begin
				if (out_free) begin
					state_next = flcu_pkg::ST_IDLE;
				end
			end
			default: state_next = flcu_pkg::ST_IDLE;
		endcase
	end

	// Datapath working signals.
	logic signed [33:0] move_d, pos_sum;
	logic signed [29:0] look_d, p_clamped;
	logic signed [21:0] zs, z1;
	logic [5:0] sq_sh;
	logic [63:0] sq_bit, sq_sum;
	logic [45:0] dv_trial;
	logic [31:0] mag;
	logic [15:0] qv;
	logic signed [15:0] nv;
	logic signed [31:0] ang, dx, dy, at, rr;
	logic signed [15:0] rc, rs;
	logic signed [65:0] prod_r;

	always_comb begin
		move_d = mul_p[55:22];
		if (dir_q == flcu_pkg::DIR_BACK || dir_q == flcu_pkg::DIR_LEFT ||
			dir_q == flcu_pkg::DIR_DOWN) begin
			pos_sum = 34'(pos_q[k_q]) - move_d;
		end else begin
			pos_sum = 34'(pos_q[k_q]) + move_d;
		end
		look_d = mul_p[33:4];
		p_clamped = 30'(pitch_q) + look_d;
		if (clamp_q) begin
			if (p_clamped > $signed(flcu_pkg::PITCH_LIM[29:0])) begin
				p_clamped = flcu_pkg::PITCH_LIM[29:0];
			end else if (p_clamped < -$signed(flcu_pkg::PITCH_LIM[29:0])) begin
				p_clamped = -$signed(flcu_pkg::PITCH_LIM[29:0]);
			end
		end
		zs = $signed({6'd0, zoom_q}) - $signed({{2{yo_q[15]}}, yo_q, 4'd0});
		z1 = (zs > $signed({6'd0, zmax_q})) ? $signed({6'd0, zmax_q}) : zs;
		if (z1 < $signed({6'd0, zmin_q})) begin
			z1 = $signed({6'd0, zmin_q});
		end
		sq_sh = 6'd62 - {cnt_q, 1'b0};
		sq_bit = 64'd1 << sq_sh;
		sq_sum = rt_q + sq_bit;
		dv_trial = {14'd0, rt_q[31:0]} << cnt_q[3:0];
		mag = tv_q[k_q][31] ? 32'(-tv_q[k_q]) : 32'(tv_q[k_q]);
		qv = ({1'b0, quo_q} > 16'd16384) ? 16'd16384 : {1'b0, quo_q};
		nv = tv_q[k_q][31] ? -$signed(qv) : $signed(qv);
		ang = sel_q ? 32'(pitch_q) : 32'(yaw_q);
		dx = cy_q >>> cnt_q[3:0];
		dy = cx_q >>> cnt_q[3:0];
		at = $signed({9'd0, flcu_pkg::atan_lut(cnt_q[3:0])});
		rc = sat_q14((cx_q + 32'sd512) >>> 10);
		rs = sat_q14((cy_q + 32'sd512) >>> 10);
		if (neg_q) begin
			rc = -rc;
			rs = -rs;
		end
		rr = prod_q - mul_p[31:0];
		prod_r = mul_p + 66'sd8192;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= 16'd640;
			sens_q <= 16'd6554;
			zmin_q <= 16'd256;
			zmax_q <= 16'd11520;
			wu_q[0] <= 16'sd0;
			wu_q[1] <= flcu_pkg::ONE_Q14;
			wu_q[2] <= 16'sd0;
			pos_q[0] <= '0;
			pos_q[1] <= '0;
			pos_q[2] <= '0;
			front_q[0] <= '0;
			front_q[1] <= '0;
			front_q[2] <= -flcu_pkg::ONE_Q14;
			right_q[0] <= flcu_pkg::ONE_Q14;
			right_q[1] <= '0;
			right_q[2] <= '0;
			up_q[0] <= '0;
			up_q[1] <= flcu_pkg::ONE_Q14;
			up_q[2] <= '0;
			yaw_q <= -flcu_pkg::ANG_QUARTER[24:0];
			pitch_q <= '0;
			zoom_q <= 16'd11520;
			cnt_q <= '0;
			k_q <= '0;
			phase_q <= flcu_pkg::PH_FRONT;
			sel_q <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					flcu_pkg::CFG_SPEED: speed_q <= cfg_data;
					flcu_pkg::CFG_SENS:  sens_q <= cfg_data;
					flcu_pkg::CFG_ZMIN:  zmin_q <= cfg_data;
					flcu_pkg::CFG_ZMAX:  zmax_q <= cfg_data;
					flcu_pkg::CFG_WUP_X: wu_q[0] <= cfg_data;
					flcu_pkg::CFG_WUP_Y: wu_q[1] <= cfg_data;
					flcu_pkg::CFG_WUP_Z: wu_q[2] <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == flcu_pkg::ST_DONE && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				flcu_pkg::ST_IDLE: begin
					if (s_axis_tvalid) begin
						dir_q <= s_axis_tdata[2:0];
						dt_q <= s_axis_tdata[18:3];
						xo_q <= s_axis_tdata[34:19];
						yo_q <= s_axis_tdata[50:35];
						clamp_q <= s_axis_tdata[51];
					end
				end
				flcu_pkg::ST_MOVE_V: begin
					v_q <= mul_p[31:0];
					k_q <= 2'd0;
				end
				flcu_pkg::ST_MOVE_STEP: begin
					if (pos_sum > 34'sd2147483647) begin
						pos_q[k_q] <= 32'h7fffffff;
					end else if (pos_sum < -34'sd2147483648) begin
						pos_q[k_q] <= 32'h80000000;
					end else begin
						pos_q[k_q] <= pos_sum[31:0];
					end
					k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
				end
				flcu_pkg::ST_ZOOM: zoom_q <= z1[15:0];
				flcu_pkg::ST_LOOK_Y: ya_q <= 30'(yaw_q) + look_d;
				flcu_pkg::ST_LOOK_P: pa_q <= p_clamped;
				flcu_pkg::ST_WRAP: begin
					if (y_hi) begin
						ya_q <= ya_q - full30;
					end else if (y_lo) begin
						ya_q <= ya_q + full30;
					end
					if (p_hi) begin
						pa_q <= pa_q - full30;
					end else if (p_lo) begin
						pa_q <= pa_q + full30;
					end
					if (!y_hi && !y_lo && !p_hi && !p_lo) begin
						yaw_q <= ya_q[24:0];
						pitch_q <= pa_q[24:0];
						sel_q <= 1'b0;
					end
				end
				flcu_pkg::ST_TRIG_INIT: begin
					if (ang > flcu_pkg::ANG_QUARTER) begin
						cz_q <= ang - flcu_pkg::ANG_HALF;
						neg_q <= 1'b1;
					end else if (ang < -flcu_pkg::ANG_QUARTER) begin
						cz_q <= ang + flcu_pkg::ANG_HALF;
						neg_q <= 1'b1;
					end else begin
						cz_q <= ang;
						neg_q <= 1'b0;
					end
					cx_q <= flcu_pkg::CORDIC_X0;
					cy_q <= '0;
					cnt_q <= '0;
				end
				flcu_pkg::ST_TRIG_ITER: begin
					if (!cz_q[31]) begin
						cx_q <= cx_q - dx;
						cy_q <= cy_q + dy;
						cz_q <= cz_q - at;
					end else begin
						cx_q <= cx_q + dx;
						cy_q <= cy_q - dy;
						cz_q <= cz_q + at;
					end
					cnt_q <= cnt_q + 5'd1;
				end
				flcu_pkg::ST_TRIG_END: begin
					if (sel_q) begin
						cos_p_q <= rc;
						sin_p_q <= rs;
					end else begin
						cos_y_q <= rc;
						sin_y_q <= rs;
					end
					sel_q <= 1'b1;
				end
				flcu_pkg::ST_FRONT0: begin
					tv_q[0] <= prod_r[45:14];
					phase_q <= flcu_pkg::PH_FRONT;
				end
				flcu_pkg::ST_FRONT1: begin
					tv_q[2] <= prod_r[45:14];
					tv_q[1] <= 32'(sin_p_q);
					k_q <= 2'd0;
					acc_q <= '0;
				end
				flcu_pkg::ST_NORM_SQ: begin
					acc_q <= acc_q + mul_p[63:0];
					k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
				end
				flcu_pkg::ST_NORM_CHK: begin
					cnt_q <= '0;
					rt_q <= '0;
					k_q <= 2'd0;
					if (acc_q == 64'd0) begin
						for (int j = 0; j < 3; j++) begin
							unique case (phase_q)
								flcu_pkg::PH_FRONT: front_q[j] <= '0;
								flcu_pkg::PH_RIGHT: right_q[j] <= '0;
								default: up_q[j] <= '0;
							endcase
						end
					end
				end
				flcu_pkg::ST_NORM_ROOT: begin
					if (acc_q >= sq_sum) begin
						acc_q <= acc_q - sq_sum;
						rt_q <= (rt_q >> 1) + sq_bit;
					end else begin
						rt_q <= rt_q >> 1;
					end
					cnt_q <= cnt_q + 5'd1;
				end
				flcu_pkg::ST_DIV_LD: begin
					rem_q <= {mag, 14'd0} + {15'd0, rt_q[31:1]};
					quo_q <= '0;
					cnt_q <= 5'd14;
				end
				flcu_pkg::ST_DIV: begin
					if (rem_q >= dv_trial) begin
						rem_q <= rem_q - dv_trial;
						quo_q <= quo_q | (15'd1 << cnt_q[3:0]);
					end
					cnt_q <= cnt_q - 5'd1;
				end
				flcu_pkg::ST_DIV_ST: begin
					unique case (phase_q)
						flcu_pkg::PH_FRONT: front_q[k_q] <= nv;
						flcu_pkg::PH_RIGHT: right_q[k_q] <= nv;
						default: up_q[k_q] <= nv;
					endcase
					k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
				end
				flcu_pkg::ST_NORM_NEXT: begin
					phase_q <= phase_q + 2'd1;
					cnt_q <= '0;
				end
				flcu_pkg::ST_CROSS: begin
					if (cnt_q[0]) begin
						tv_q[cnt_q[2:1]] <= rr;
					end else begin
						prod_q <= mul_p[31:0];
					end
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd5) begin
						acc_q <= '0;
						k_q <= 2'd0;
					end
				end
				flcu_pkg::ST_DONE: begin
					if (out_free) begin
						m_data_q <= {6'd0, zoom_q, pitch_q, yaw_q,
							up_q[2], up_q[1], up_q[0],
							front_q[2], front_q[1], front_q[0],
							pos_q[2], pos_q[1], pos_q[0]};
					end
				end
				default: ;
			endcase
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input accepted twice in a row");

	a_yaw_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(yaw_q) >= -flcu_pkg::ANG_HALF) && (32'(yaw_q) < flcu_pkg::ANG_HALF))
		else $error("yaw left its wrapped range");

	a_front_unit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == flcu_pkg::ST_DONE) |->
		(front_q[0] <= flcu_pkg::ONE_Q14 && front_q[0] >= -flcu_pkg::ONE_Q14 &&
		 front_q[1] <= flcu_pkg::ONE_Q14 && front_q[1] >= -flcu_pkg::ONE_Q14 &&
		 front_q[2] <= flcu_pkg::ONE_Q14 && front_q[2] >= -flcu_pkg::ONE_Q14))
		else $error("front vector component out of range");

endmodule
